@@ rtl/imh_pkg.sv @@
// Package for the indexed min-heap core: sizes, command and status codes.
// Used by the channel interfaces and by indexed_min_heap_core; depends on nothing.
`default_nettype none

package imh_pkg;

  localparam int MAX_ELEMENTS = 15;
  localparam int WEIGHT_BITS  = 16;

  // Field widths of the item formats.
  localparam int CMD_W    = 2;
  localparam int ELEM_W   = 4;
  localparam int IN_WT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  // Slots 1..MAX_ELEMENTS and labels 1..MAX_ELEMENTS share one index width.
  localparam int SLOT_W    = ELEM_W;
  localparam int TBL_DEPTH = MAX_ELEMENTS + 1;

  localparam logic [ELEM_W-1:0] MAX_LABEL = ELEM_W'(MAX_ELEMENTS);

  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LABEL = 2'd3;

endpackage

`default_nettype wire

@@ rtl/imh_ifs.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on imh_pkg for the field widths.
`default_nettype none

interface imh_in_if;
  logic                          valid;
  logic                          ready;
  logic [imh_pkg::CMD_W-1:0]     cmd;
  logic [imh_pkg::ELEM_W-1:0]    element;
  logic [imh_pkg::IN_WT_W-1:0]   weight;

  modport source (output valid, output cmd, output element, output weight, input ready);
  modport sink   (input valid, input cmd, input element, input weight, output ready);
endinterface

interface imh_out_if;
  logic                          valid;
  logic                          ready;
  logic [imh_pkg::ELEM_W-1:0]    extracted;
  logic                          was_present;
  logic [imh_pkg::ELEM_W-1:0]    top_element;
  logic [imh_pkg::COUNT_W-1:0]   count;
  logic [imh_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output extracted, output was_present, output top_element,
                  output count, output status, input ready);
  modport sink   (input valid, input extracted, input was_present, input top_element,
                  input count, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/indexed_min_heap_core.sv @@
// Indexed binary min-heap over labels 1..15 with 16-bit weights. Commands are insert,
// extract-min and clear; each command item yields one result item. Depends on imh_pkg, imh_ifs.
// The core takes one command at a time; in_ch.ready is high only while the sequencer is idle.
// Every heap level costs sequencer steps around one shared 16-bit comparator and one read
// port per table. An insert climbs in S_UP (at most 3 levels) and then writes its own slot in
// S_FIN. An extract reads the root in S_EX1 and moves the last entry in S_EX2; that entry then
// sinks through S_D1, S_D2 and S_D3 (at most 3 levels) until it reaches a leaf or a child
// stops it, and S_FIN is skipped when the extract removes the only element. Clear, the unused
// command and the error cases go straight to S_TOP, which registers the result. A finished
// result waits in the output register while the next command is accepted; the sequencer
// stalls only when a second result is ready and the first has not been taken.
`default_nettype none

module indexed_min_heap_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  imh_in_if.sink          in_ch,
  imh_out_if.source       out_ch
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EX1  = 4'd1;
  localparam logic [3:0] S_EX2  = 4'd2;
  localparam logic [3:0] S_UP   = 4'd3;
  localparam logic [3:0] S_D1   = 4'd4;
  localparam logic [3:0] S_D2   = 4'd5;
  localparam logic [3:0] S_D3   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_TOP  = 4'd8;

  localparam logic [imh_pkg::SLOT_W-1:0] ROOT_SLOT = imh_pkg::SLOT_W'(1);

  // Heap tables. Only the slot of each element has a defined reset.
  logic [imh_pkg::ELEM_W-1:0]      s2e_r [imh_pkg::TBL_DEPTH];
  logic [imh_pkg::WEIGHT_BITS-1:0] wgt_r [imh_pkg::TBL_DEPTH];
  logic [imh_pkg::SLOT_W-1:0]      e2s_r [imh_pkg::TBL_DEPTH];

  logic [3:0]                      st_r, st_nxt;
  logic [imh_pkg::COUNT_W-1:0]     size_r, size_nxt;
  logic [imh_pkg::ELEM_W-1:0]      elem_r, elem_nxt;
  logic [imh_pkg::WEIGHT_BITS-1:0] wt_r, wt_nxt;
  logic [imh_pkg::SLOT_W-1:0]      s_r, s_nxt;
  logic [imh_pkg::SLOT_W-1:0]      c_r, c_nxt;
  logic [imh_pkg::ELEM_W-1:0]      ce_r, ce_nxt;
  logic [imh_pkg::WEIGHT_BITS-1:0] cw_r, cw_nxt;
  logic                            present_r, present_nxt;
  logic [imh_pkg::ELEM_W-1:0]      extr_r, extr_nxt;
  logic [imh_pkg::STATUS_W-1:0]    status_r, status_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [imh_pkg::ELEM_W-1:0]      out_extr_r, out_extr_nxt;
  logic                            out_pres_r, out_pres_nxt;
  logic [imh_pkg::ELEM_W-1:0]      out_top_r, out_top_nxt;
  logic [imh_pkg::COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic [imh_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;

  // Single read port per table: slot -> element -> weight.
  logic [imh_pkg::SLOT_W-1:0]      rd_slot;
  logic [imh_pkg::ELEM_W-1:0]      rd_elem;
  logic [imh_pkg::WEIGHT_BITS-1:0] rd_wt;

  // Shared comparator.
  logic [imh_pkg::WEIGHT_BITS-1:0] cmp_a, cmp_b;
  logic                            cmp_lt;

  // Write ports.
  logic                            s2e_we;
  logic [imh_pkg::SLOT_W-1:0]      s2e_wa;
  logic [imh_pkg::ELEM_W-1:0]      s2e_wd;
  logic                            e2s_we, e2s_clr;
  logic [imh_pkg::ELEM_W-1:0]      e2s_wa;
  logic [imh_pkg::SLOT_W-1:0]      e2s_wd;
  logic                            wgt_we;

  logic                            in_fire, out_fire;
  logic                            lbl_ok;
  logic [imh_pkg::SLOT_W:0]        left_slot;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  assign rd_elem = s2e_r[rd_slot];
  assign rd_wt   = wgt_r[rd_elem];
  assign cmp_lt  = cmp_a < cmp_b;

  assign lbl_ok    = (in_ch.element != '0) && (in_ch.element <= imh_pkg::MAX_LABEL);
  assign left_slot = {s_r, 1'b0};

  assign in_ch.ready        = (st_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.extracted   = out_extr_r;
  assign out_ch.was_present = out_pres_r;
  assign out_ch.top_element = out_top_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.status      = out_status_r;

  always_comb begin
    st_nxt         = st_r;
    size_nxt       = size_r;
    elem_nxt       = elem_r;
    wt_nxt         = wt_r;
    s_nxt          = s_r;
    c_nxt          = c_r;
    ce_nxt         = ce_r;
    cw_nxt         = cw_r;
    present_nxt    = present_r;
    extr_nxt       = extr_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_fire ? 1'b0 : out_valid_r;
    out_extr_nxt   = out_extr_r;
    out_pres_nxt   = out_pres_r;
    out_top_nxt    = out_top_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    rd_slot        = ROOT_SLOT;
    cmp_a          = wt_r;
    cmp_b          = rd_wt;
    s2e_we         = 1'b0;
    s2e_wa         = s_r;
    s2e_wd         = elem_r;
    e2s_we         = 1'b0;
    e2s_clr        = 1'b0;
    e2s_wa         = elem_r;
    e2s_wd         = s_r;
    wgt_we         = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          present_nxt = lbl_ok && (e2s_r[in_ch.element] != '0);
          elem_nxt    = in_ch.element;
          wt_nxt      = in_ch.weight[imh_pkg::WEIGHT_BITS-1:0];
          extr_nxt    = '0;
          status_nxt  = imh_pkg::ST_OK;
          st_nxt      = S_TOP;
          case (in_ch.cmd)
            imh_pkg::CMD_INSERT: begin
              if (!lbl_ok) begin
                status_nxt = imh_pkg::ST_BAD_LABEL;
              end else if (e2s_r[in_ch.element] != '0) begin
                status_nxt = imh_pkg::ST_DUPLICATE;
              end else if (size_r < imh_pkg::COUNT_W'(imh_pkg::MAX_ELEMENTS)) begin
                wgt_we   = 1'b1;
                size_nxt = size_r + 1'b1;
                s_nxt    = size_r + 1'b1;
                st_nxt   = S_UP;
              end
            end
            imh_pkg::CMD_EXTRACT: begin
              if (size_r == '0) begin
                status_nxt = imh_pkg::ST_EMPTY;
              end else begin
                st_nxt = S_EX1;
              end
            end
            imh_pkg::CMD_CLEAR: begin
              e2s_clr  = 1'b1;
              size_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_UP: begin
        // The new element climbs while its parent is strictly heavier.
        rd_slot = s_r >> 1;
        cmp_a   = wt_r;
        cmp_b   = rd_wt;
        if ((s_r > ROOT_SLOT) && cmp_lt) begin
          s2e_we = 1'b1;
          s2e_wa = s_r;
          s2e_wd = rd_elem;
          e2s_we = 1'b1;
          e2s_wa = rd_elem;
          e2s_wd = s_r;
          s_nxt  = s_r >> 1;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_EX1: begin
        rd_slot  = ROOT_SLOT;
        extr_nxt = rd_elem;
        e2s_we   = 1'b1;
        e2s_wa   = rd_elem;
        e2s_wd   = '0;
        st_nxt   = S_EX2;
      end
      S_EX2: begin
        // Unless it was the only entry, the last entry moves to the root and then sinks.
        rd_slot  = size_r;
        elem_nxt = rd_elem;
        wt_nxt   = rd_wt;
        size_nxt = size_r - 1'b1;
        s_nxt    = ROOT_SLOT;
        st_nxt   = (size_r > imh_pkg::COUNT_W'(1)) ? S_D1 : S_TOP;
      end
      S_D1: begin
        rd_slot = left_slot[imh_pkg::SLOT_W-1:0];
        if (left_slot > {1'b0, size_r}) begin
          st_nxt = S_FIN;
        end else begin
          c_nxt  = left_slot[imh_pkg::SLOT_W-1:0];
          ce_nxt = rd_elem;
          cw_nxt = rd_wt;
          st_nxt = S_D2;
        end
      end
      S_D2: begin
        // The right child wins only when strictly lighter than the left one.
        rd_slot = c_r + 1'b1;
        cmp_a   = rd_wt;
        cmp_b   = cw_r;
        if ((c_r < size_r) && cmp_lt) begin
          c_nxt  = c_r + 1'b1;
          ce_nxt = rd_elem;
          cw_nxt = rd_wt;
        end
        st_nxt = S_D3;
      end
      S_D3: begin
        cmp_a = cw_r;
        cmp_b = wt_r;
        if (cmp_lt) begin
          s2e_we = 1'b1;
          s2e_wa = s_r;
          s2e_wd = ce_r;
          e2s_we = 1'b1;
          e2s_wa = ce_r;
          e2s_wd = s_r;
          s_nxt  = c_r;
          st_nxt = S_D1;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        s2e_we = 1'b1;
        s2e_wa = s_r;
        s2e_wd = elem_r;
        e2s_we = 1'b1;
        e2s_wa = elem_r;
        e2s_wd = s_r;
        st_nxt = S_TOP;
      end
      S_TOP: begin
        rd_slot = ROOT_SLOT;
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_extr_nxt   = extr_r;
          out_pres_nxt   = present_r;
          out_top_nxt    = (size_r != '0) ? rd_elem : '0;
          out_count_nxt  = size_r;
          out_status_nxt = status_r;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r       <= elem_nxt;
    wt_r         <= wt_nxt;
    s_r          <= s_nxt;
    c_r          <= c_nxt;
    ce_r         <= ce_nxt;
    cw_r         <= cw_nxt;
    present_r    <= present_nxt;
    extr_r       <= extr_nxt;
    status_r     <= status_nxt;
    out_extr_r   <= out_extr_nxt;
    out_pres_r   <= out_pres_nxt;
    out_top_r    <= out_top_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (s2e_we) begin
      s2e_r[s2e_wa] <= s2e_wd;
    end
    if (wgt_we) begin
      wgt_r[in_ch.element] <= in_ch.weight[imh_pkg::WEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || e2s_clr) begin
      for (int i = 0; i < imh_pkg::TBL_DEPTH; i++) begin
        e2s_r[i] <= '0;
      end
    end else if (e2s_we) begin
      e2s_r[e2s_wa] <= e2s_wd;
    end
  end

  // The heap never holds more elements than there are labels.
  assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= imh_pkg::COUNT_W'(imh_pkg::MAX_ELEMENTS))
    else $error("heap count above the number of labels");

  // One command is worked on at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("command accepted while the previous one is in progress");

  // An empty heap reports no top element.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_count_r == '0)) |-> (out_top_r == '0))
    else $error("empty heap reports a top element");

  // An extract on an empty heap removes nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == imh_pkg::ST_EMPTY)) |->
      ((out_extr_r == '0) && (out_count_r == '0)))
    else $error("failed extract reports a removed element");

  // While sinking, the chosen child always lies inside the heap.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_D3) |-> ((c_r <= size_r) && (c_r > s_r)))
    else $error("sift-down child outside the heap");

endmodule

`default_nettype wire

@@ tb/sv/indexed_min_heap_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for indexed_min_heap_core: directed and random command items
// over valid/ready channels, each result checked against a heap predictor in this file.
// Depends on imh_pkg, the channel interfaces in imh_ifs and the core itself.

module indexed_min_heap_core_tb;

  // Command code that the core must treat as a no-op.
  localparam logic [imh_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 288;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [imh_pkg::CMD_W-1:0]   cmd;
    logic [imh_pkg::ELEM_W-1:0]  element;
    logic [imh_pkg::IN_WT_W-1:0] weight;
  } heap_cmd_t;

  typedef struct packed {
    logic [imh_pkg::ELEM_W-1:0]   extracted;
    logic                         was_present;
    logic [imh_pkg::ELEM_W-1:0]   top_element;
    logic [imh_pkg::COUNT_W-1:0]  count;
    logic [imh_pkg::STATUS_W-1:0] status;
  } heap_result_t;

  typedef struct packed {
    logic [imh_pkg::TBL_DEPTH-1:0][imh_pkg::ELEM_W-1:0]      slot_elem;
    logic [imh_pkg::TBL_DEPTH-1:0][imh_pkg::SLOT_W-1:0]      elem_slot;
    logic [imh_pkg::TBL_DEPTH-1:0][imh_pkg::WEIGHT_BITS-1:0] elem_wt;
    logic [imh_pkg::COUNT_W-1:0]                             occupancy;
  } heap_state_t;

  logic clk = 1'b0;
  logic rst_n;

  imh_in_if  in_ch ();
  imh_out_if out_ch ();

  indexed_min_heap_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  heap_cmd_t    cmd_backlog[$];
  heap_result_t result_due[$];
  heap_state_t  model_state;
  heap_state_t  gen_state;
  heap_cmd_t    staged;
  heap_result_t predicted;
  heap_result_t observed;
  heap_result_t wanted;
  logic         in_fired;
  logic         filling;
  int           fill_target;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           mismatch_cnt;
  int           cycle_cnt;

  // Applies one command to a heap image and returns the result item it yields.
  function automatic heap_result_t heap_apply(inout heap_state_t st, input heap_cmd_t c);
    heap_result_t r;
    int s;
    int k;
    int n;
    logic done;
    logic label_ok;
    logic [imh_pkg::ELEM_W-1:0] e;
    logic [imh_pkg::ELEM_W-1:0] moved;
    logic [imh_pkg::WEIGHT_BITS-1:0] w;
    r = '0;
    label_ok = (c.element >= 1) && (c.element <= imh_pkg::MAX_LABEL);
    r.was_present = label_ok && (st.elem_slot[c.element] != '0);
    case (c.cmd)
      imh_pkg::CMD_INSERT: begin
        if (!label_ok) begin
          r.status = imh_pkg::ST_BAD_LABEL;
        end else if (r.was_present) begin
          r.status = imh_pkg::ST_DUPLICATE;
        end else if (st.occupancy < imh_pkg::MAX_ELEMENTS) begin
          st.occupancy = st.occupancy + 1'b1;
          e = c.element;
          w = c.weight[imh_pkg::WEIGHT_BITS-1:0];
          st.elem_wt[e] = w;
          s = st.occupancy;
          // Heavier parents move down one level until the new weight fits.
          while (s > 1 && st.elem_wt[st.slot_elem[s/2]] > w) begin
            moved = st.slot_elem[s/2];
            st.slot_elem[s] = moved;
            st.elem_slot[moved] = imh_pkg::SLOT_W'(s);
            s = s / 2;
          end
          st.slot_elem[s] = e;
          st.elem_slot[e] = imh_pkg::SLOT_W'(s);
        end
      end
      imh_pkg::CMD_EXTRACT: begin
        if (st.occupancy == '0) begin
          r.status = imh_pkg::ST_EMPTY;
        end else begin
          r.extracted = st.slot_elem[1];
          e = st.slot_elem[st.occupancy];
          st.occupancy = st.occupancy - 1'b1;
          st.elem_slot[r.extracted] = '0;
          n = st.occupancy;
          if (n > 0) begin
            w = st.elem_wt[e];
            s = 1;
            done = 1'b0;
            // The right child wins only when strictly lighter, and a child rises
            // only when strictly lighter than the element sinking from the root.
            while (!done) begin
              k = 2 * s;
              if (k > n) begin
                done = 1'b1;
              end else begin
                if (k < n && st.elem_wt[st.slot_elem[k+1]] < st.elem_wt[st.slot_elem[k]])
                  k = k + 1;
                if (st.elem_wt[st.slot_elem[k]] < w) begin
                  moved = st.slot_elem[k];
                  st.slot_elem[s] = moved;
                  st.elem_slot[moved] = imh_pkg::SLOT_W'(s);
                  s = k;
                end else begin
                  done = 1'b1;
                end
              end
            end
            st.slot_elem[s] = e;
            st.elem_slot[e] = imh_pkg::SLOT_W'(s);
          end
        end
      end
      imh_pkg::CMD_CLEAR: begin
        st.elem_slot = '0;
        st.occupancy = '0;
      end
      default: ;
    endcase
    r.top_element = (st.occupancy != '0) ? st.slot_elem[1] : '0;
    r.count = st.occupancy;
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 68; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 68; end
      default:       begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // The generator keeps its own heap image so that it knows which labels are present.
  task automatic push_cmd(input logic [imh_pkg::CMD_W-1:0] cmd, input int element,
                          input int weight);
    heap_cmd_t item;
    item.cmd = cmd;
    item.element = imh_pkg::ELEM_W'(element);
    item.weight = imh_pkg::IN_WT_W'(weight);
    void'(heap_apply(gen_state, item));
    cmd_backlog.push_back(item);
  endtask

  function automatic int pick_weight();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 3);
      1:       return 65535 - $urandom_range(0, 3);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Mostly fill-then-drain runs toward a random size, with noise mixed in.
  task automatic queue_random(input int n);
    int absent[$];
    int present[$];
    int roll;
    for (int i = 0; i < n; i++) begin
      absent.delete();
      present.delete();
      for (int lbl = 1; lbl <= imh_pkg::MAX_ELEMENTS; lbl++) begin
        if (gen_state.elem_slot[lbl] == '0)
          absent.push_back(lbl);
        else
          present.push_back(lbl);
      end
      roll = $urandom_range(0, 99);
      if (roll >= 85) begin
        case ($urandom_range(0, 5))
          0: push_cmd(imh_pkg::CMD_INSERT, $urandom_range(0, 15), pick_weight());
          1: push_cmd(imh_pkg::CMD_INSERT, 0, pick_weight());
          2: push_cmd(imh_pkg::CMD_CLEAR, $urandom_range(0, 15), pick_weight());
          3: push_cmd(CMD_NOP, $urandom_range(0, 15), pick_weight());
          4: push_cmd(imh_pkg::CMD_EXTRACT, $urandom_range(0, 15), pick_weight());
          default: begin
            if (present.size() != 0)
              push_cmd(imh_pkg::CMD_INSERT, present[$urandom_range(0, present.size() - 1)],
                       pick_weight());
            else
              push_cmd(imh_pkg::CMD_INSERT, $urandom_range(0, 15), pick_weight());
          end
        endcase
      end else if ((filling ? roll < 70 : roll < 15) && absent.size() != 0) begin
        push_cmd(imh_pkg::CMD_INSERT, absent[$urandom_range(0, absent.size() - 1)],
                 pick_weight());
      end else begin
        push_cmd(imh_pkg::CMD_EXTRACT, $urandom_range(0, 15), pick_weight());
      end
      if (gen_state.occupancy >= fill_target) begin
        filling = 1'b0;
      end else if (gen_state.occupancy == '0) begin
        filling = 1'b1;
        fill_target = $urandom_range(0, 1) ? imh_pkg::MAX_ELEMENTS
                                           : $urandom_range(1, imh_pkg::MAX_ELEMENTS);
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_ch.valid || result_due.size() != 0)
      @(posedge clk);
  endtask

  // Driver: a raised valid holds its item until the core takes it.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && !in_fired) begin
        // Hold the current item.
      end else if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        staged = cmd_backlog.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= staged.cmd;
        in_ch.element <= staged.element;
        in_ch.weight  <= staged.weight;
      end else begin
        in_ch.valid <= 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: checks the result item first, then predicts for a newly taken command.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (result_due.size() == 0) begin
          report_error("result item arrived with nothing outstanding");
        end else begin
          wanted = result_due.pop_front();
          observed.extracted   = out_ch.extracted;
          observed.was_present = out_ch.was_present;
          observed.top_element = out_ch.top_element;
          observed.count       = out_ch.count;
          observed.status      = out_ch.status;
          check_field("extracted", 16'(observed.extracted), 16'(wanted.extracted));
          check_field("was_present", 16'(observed.was_present), 16'(wanted.was_present));
          check_field("top_element", 16'(observed.top_element), 16'(wanted.top_element));
          check_field("count", 16'(observed.count), 16'(wanted.count));
          check_field("status", 16'(observed.status), 16'(wanted.status));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted = heap_apply(model_state, {in_ch.cmd, in_ch.element, in_ch.weight});
        result_due.push_back(predicted);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.element = '0;
    in_ch.weight = '0;
    out_ch.ready = 1'b0;
    model_state = '0;
    gen_state = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    filling = 1'b1;
    fill_target = imh_pkg::MAX_ELEMENTS;
    set_idle(IDLE_NONE);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_cmd(imh_pkg::CMD_EXTRACT, 0, 0);
    push_cmd(CMD_NOP, 5, 16'h1234);
    push_cmd(imh_pkg::CMD_INSERT, 0, 16'hFFFF);
    push_cmd(imh_pkg::CMD_INSERT, 15, 16'hFFFF);
    push_cmd(imh_pkg::CMD_INSERT, 1, 16'h0000);
    push_cmd(imh_pkg::CMD_INSERT, 1, 16'h0005);
    push_cmd(imh_pkg::CMD_INSERT, 8, 16'h0000);
    push_cmd(imh_pkg::CMD_INSERT, 3, 16'h8000);
    push_cmd(imh_pkg::CMD_INSERT, 4, 16'h7FFF);
    push_cmd(imh_pkg::CMD_EXTRACT, 1, 0);
    push_cmd(imh_pkg::CMD_EXTRACT, 0, 16'hFFFF);
    push_cmd(CMD_NOP, 15, 16'hFFFF);
    push_cmd(imh_pkg::CMD_EXTRACT, 15, 0);
    push_cmd(imh_pkg::CMD_CLEAR, 8, 16'hAAAA);
    // Labels cleared away must read as absent again.
    push_cmd(imh_pkg::CMD_EXTRACT, 3, 0);
    push_cmd(imh_pkg::CMD_INSERT, 3, 16'h5555);
    push_cmd(imh_pkg::CMD_EXTRACT, 3, 0);
    push_cmd(imh_pkg::CMD_EXTRACT, 9, 0);
    push_cmd(imh_pkg::CMD_CLEAR, 0, 0);
    wait_drained();

    set_idle(IDLE_NONE);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();
    set_idle(IDLE_SENDER);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();
    set_idle(IDLE_RECEIVER);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();
    set_idle(IDLE_BOTH);
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_due.size() != 0)
      report_error($sformatf("%0d result items never arrived", result_due.size()));
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ indexed_min_heap_core.f @@
rtl/imh_pkg.sv
rtl/imh_ifs.sv
rtl/indexed_min_heap_core.sv
tb/sv/indexed_min_heap_core_tb.sv
